>>> rtl/cbtr_pkg.sv
// Shared types, constants and codes for the broadcast transport reassembler.
package cbtr_pkg;

   localparam int SESSIONS     = 4;
   localparam int BUFFER_BYTES = 256;

   localparam int SID_W   = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
   localparam int RAM_DEPTH = SESSIONS * BUFFER_BYTES;
   localparam int ADDR_W  = $clog2(RAM_DEPTH);
   localparam int CNT_W   = $clog2(BUFFER_BYTES + 1);
   localparam int POS_W   = 11;
   localparam int MAX_CHUNKS = 32;
   localparam int CHUNK_W = $clog2(MAX_CHUNKS);

   localparam logic [23:0] GROUP_CM      = 24'd60416;
   localparam logic [23:0] GROUP_DT      = 24'd60160;
   localparam logic [7:0]  CTRL_ANNOUNCE = 8'd32;
   localparam logic [7:0]  PDU2_FIRST_PF = 8'd240;
   localparam logic [15:0] TIMEOUT_RESET = 16'd750;

   localparam logic [3:0] STAT_IGNORED  = 4'd0;
   localparam logic [3:0] STAT_ANNOUNCE = 4'd1;
   localparam logic [3:0] STAT_NO_FREE  = 4'd2;
   localparam logic [3:0] STAT_DATA     = 4'd3;
   localparam logic [3:0] STAT_COMPLETE = 4'd4;
   localparam logic [3:0] STAT_NO_RECV  = 4'd5;
   localparam logic [3:0] STAT_TIMEOUT  = 4'd6;
   localparam logic [3:0] STAT_SEQUENCE = 4'd7;
   localparam logic [3:0] STAT_BAD_LEN  = 4'd8;
   localparam logic [3:0] STAT_NOTHING  = 4'd9;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_RECV = 2'd1,
      MODE_DONE = 2'd2,
      MODE_ERR  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      OP_OTHER    = 3'd0,
      OP_BADLEN   = 3'd1,
      OP_ANNOUNCE = 3'd2,
      OP_DATA     = 3'd3,
      OP_FETCH    = 3'd4
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [23:0] group;
      logic [7:0]  src;
      logic [2:0]  pri;
      logic [7:0]  dst;
      logic [63:0] bytes;
      logic [31:0] ts;
      logic [15:0] max_len;
   } cmd_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  status;
      logic [23:0] pgn;
      logic [7:0]  sender_addr;
      logic [2:0]  priority_res;
      logic [7:0]  destination;
      logic [63:0] chunk_data;
      logic [3:0]  chunk_len;
      logic [15:0] message_length;
      logic [15:0] complete_count;
      logic        last;
   } rsp_type;

endpackage

>>> rtl/cbtr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cbtr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/cbtr_front.sv
// Front end: accepts items, decodes identifiers, classifies and queues them.
module cbtr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic [28:0]           req_can_id,
   input  logic [3:0]            req_frame_length,
   input  logic [63:0]           req_payload,
   input  logic [31:0]           req_timestamp_ms,
   input  logic [7:0]            req_fetch_source,
   input  logic [15:0]           req_fetch_max_len,
   output logic                  cmd_valid,
   output cbtr_pkg::cmd_type     cmd,
   input  logic                  cmd_pop
);

   cbtr_pkg::cmd_type q_ff [2];
   logic [1:0]        count_ff, count_in;
   logic              head_ff, head_in, tail_ff, tail_in;
   cbtr_pkg::cmd_type dec;
   logic [7:0]        pf, ps;
   logic              push;

   assign pf = req_can_id[23:16];
   assign ps = req_can_id[15:8];

   always_comb begin
      dec.group = {6'd0, req_can_id[25:24], pf, (pf < cbtr_pkg::PDU2_FIRST_PF) ? 8'h00 : ps};
      dec.pri   = req_can_id[28:26];
      dec.dst   = (pf < cbtr_pkg::PDU2_FIRST_PF) ? ps : 8'hFF;
      dec.ts    = req_timestamp_ms;
      dec.max_len = req_fetch_max_len;
      dec.src   = req_type ? req_fetch_source : req_can_id[7:0];
      for (int i = 0; i < 8; i++) begin
         dec.bytes[8*i +: 8] = (4'(i) < req_frame_length) ? req_payload[8*i +: 8] : 8'h00;
      end
      if (req_type) begin
         dec.op = cbtr_pkg::OP_FETCH;
      end else if (req_frame_length == 4'd0 || req_frame_length > 4'd8) begin
         dec.op = cbtr_pkg::OP_BADLEN;
      end else if (dec.group == cbtr_pkg::GROUP_CM) begin
         dec.op = (dec.bytes[7:0] == cbtr_pkg::CTRL_ANNOUNCE) ? cbtr_pkg::OP_ANNOUNCE
                                                             : cbtr_pkg::OP_OTHER;
      end else if (dec.group == cbtr_pkg::GROUP_DT) begin
         dec.op = cbtr_pkg::OP_DATA;
      end else begin
         dec.op = cbtr_pkg::OP_OTHER;
      end
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[head_ff];

   always_comb begin
      head_in  = cmd_pop ? ~head_ff : head_ff;
      tail_in  = push ? ~tail_ff : tail_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
      if (push) begin
         q_ff[tail_ff] <= dec;
      end
   end

endmodule

>>> rtl/cbtr_back.sv
// Back end: session table, buffer writes, fetch draining and the result register.
module cbtr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata,
   input  logic              cmd_valid,
   input  cbtr_pkg::cmd_type cmd,
   output logic              cmd_pop,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output cbtr_pkg::rsp_type rsp
);

   typedef enum logic [4:0] {
      BK_IDLE  = 5'b00001,
      BK_WRITE = 5'b00010,
      BK_READ  = 5'b00100,
      BK_CAPT  = 5'b01000,
      BK_SEND  = 5'b10000
   } bk_state_type;

   localparam int S = cbtr_pkg::SESSIONS;
   localparam int SW = cbtr_pkg::SID_W;
   localparam int CW = cbtr_pkg::CNT_W;
   localparam int PW = cbtr_pkg::POS_W;
   localparam int AW = cbtr_pkg::ADDR_W;
   localparam int KW = cbtr_pkg::CHUNK_W;

   bk_state_type       state_ff, state_in;
   cbtr_pkg::mode_type mode_ff [S], mode_in [S];
   logic [7:0]         src_ff [S], src_in [S];
   logic [15:0]        len_ff [S], len_in [S];
   logic [7:0]         pkts_ff [S], pkts_in [S];
   logic [23:0]        grp_ff [S], grp_in [S];
   logic [7:0]         rcv_ff [S], rcv_in [S];
   logic [31:0]        time_ff [S], time_in [S];
   logic [15:0]        timeout_ff, timeout_in;
   logic [15:0]        count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cbtr_pkg::rsp_type  rsp_ff, rsp_in;

   logic [SW-1:0]      sid_ff, sid_in;
   logic [PW-1:0]      wr_base_ff, wr_base_in;
   logic [15:0]        wr_lim_ff, wr_lim_in;
   logic [55:0]        wr_bytes_ff, wr_bytes_in;
   logic [2:0]         wr_i_ff, wr_i_in;
   logic [CW-1:0]      copy_ff, copy_in, pos_ff, pos_in;
   logic [PW-1:0]      wmark_ff, wmark_in;
   logic [3:0]         byte_ff, byte_in;
   logic [KW-1:0]      chunk_ff, chunk_in;
   logic [63:0]        data_ff, data_in;
   logic [23:0]        fgrp_ff, fgrp_in;
   logic [7:0]         fsrc_ff, fsrc_in;

   logic               match_found, free_found, out_free, last_chunk;
   logic [SW-1:0]      match_idx, free_idx, ann_idx;
   logic [31:0]        gap;
   logic [15:0]        clamp, wr_lim_calc;
   logic [PW-1:0]      wr_pos;
   logic [8:0]         next_rcv;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [7:0]         ram_wdata, ram_rdata, cap_byte;

   cbtr_ram #(.WIDTH(8), .DEPTH(cbtr_pkg::RAM_DEPTH)) u_buf (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      match_found = 1'b0;
      free_found  = 1'b0;
      match_idx   = '0;
      free_idx    = '0;
      for (int i = S - 1; i >= 0; i--) begin
         if (mode_ff[i] != cbtr_pkg::MODE_IDLE && src_ff[i] == cmd.src) begin
            match_found = 1'b1;
            match_idx   = SW'(i);
         end
         if (mode_ff[i] == cbtr_pkg::MODE_IDLE) begin
            free_found = 1'b1;
            free_idx   = SW'(i);
         end
      end
   end

   assign ann_idx   = match_found ? match_idx : free_idx;
   assign gap       = cmd.ts - time_ff[match_idx];
   assign next_rcv  = {1'b0, rcv_ff[match_idx]} + 9'd1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign wr_pos    = wr_base_ff + PW'(wr_i_ff);
   assign last_chunk = (pos_ff == copy_ff) || (chunk_ff == KW'(cbtr_pkg::MAX_CHUNKS - 1));
   assign cap_byte  = (PW'(pos_ff) < wmark_ff) ? ram_rdata : 8'hFF;
   assign wr_lim_calc = (len_ff[match_idx] < 16'(cbtr_pkg::BUFFER_BYTES))
                      ? len_ff[match_idx] : 16'(cbtr_pkg::BUFFER_BYTES);

   always_comb begin
      clamp = (len_ff[match_idx] < cmd.max_len) ? len_ff[match_idx] : cmd.max_len;
      if (clamp > 16'(cbtr_pkg::BUFFER_BYTES)) begin
         clamp = 16'(cbtr_pkg::BUFFER_BYTES);
      end
   end

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      src_in = src_ff;
      len_in = len_ff;
      pkts_in = pkts_ff;
      grp_in = grp_ff;
      rcv_in = rcv_ff;
      time_in = time_ff;
      timeout_in = csr_we ? csr_wdata : timeout_ff;
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      sid_in = sid_ff;
      wr_base_in = wr_base_ff;
      wr_lim_in = wr_lim_ff;
      wr_bytes_in = wr_bytes_ff;
      wr_i_in = wr_i_ff;
      copy_in = copy_ff;
      pos_in = pos_ff;
      wmark_in = wmark_ff;
      byte_in = byte_ff;
      chunk_in = chunk_ff;
      data_in = data_ff;
      fgrp_in = fgrp_ff;
      fsrc_in = fsrc_ff;
      cmd_pop = 1'b0;
      ram_we = 1'b0;
      ram_waddr = AW'(sid_ff) * AW'(cbtr_pkg::BUFFER_BYTES) + AW'(wr_pos);
      ram_wdata = wr_bytes_ff[8*wr_i_ff +: 8];
      ram_raddr = AW'(sid_ff) * AW'(cbtr_pkg::BUFFER_BYTES) + AW'(pos_ff);

      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in.kind = 1'b0;
               rsp_in.status = cbtr_pkg::STAT_IGNORED;
               rsp_in.pgn = cmd.group;
               rsp_in.sender_addr = cmd.src;
               rsp_in.priority_res = cmd.pri;
               rsp_in.destination = cmd.dst;
               rsp_in.chunk_data = '0;
               rsp_in.chunk_len = '0;
               rsp_in.message_length = '0;
               rsp_in.complete_count = count_ff;
               rsp_in.last = 1'b1;
               case (cmd.op)
                  cbtr_pkg::OP_BADLEN: begin
                     rsp_in.status = cbtr_pkg::STAT_BAD_LEN;
                  end
                  cbtr_pkg::OP_ANNOUNCE: begin
                     if (match_found || free_found) begin
                        rsp_in.status = cbtr_pkg::STAT_ANNOUNCE;
                        mode_in[ann_idx] = cbtr_pkg::MODE_RECV;
                        src_in[ann_idx] = cmd.src;
                        len_in[ann_idx] = cmd.bytes[23:8];
                        pkts_in[ann_idx] = cmd.bytes[31:24];
                        grp_in[ann_idx] = cmd.bytes[63:40];
                        rcv_in[ann_idx] = 8'd0;
                        time_in[ann_idx] = cmd.ts;
                     end else begin
                        rsp_in.status = cbtr_pkg::STAT_NO_FREE;
                     end
                  end
                  cbtr_pkg::OP_DATA: begin
                     if (!match_found || mode_ff[match_idx] != cbtr_pkg::MODE_RECV) begin
                        rsp_in.status = cbtr_pkg::STAT_NO_RECV;
                     end else if (gap > {16'd0, timeout_ff}) begin
                        rsp_in.status = cbtr_pkg::STAT_TIMEOUT;
                        mode_in[match_idx] = cbtr_pkg::MODE_ERR;
                     end else if ({1'b0, cmd.bytes[7:0]} != next_rcv) begin
                        rsp_in.status = cbtr_pkg::STAT_SEQUENCE;
                        mode_in[match_idx] = cbtr_pkg::MODE_ERR;
                     end else begin
                        sid_in = match_idx;
                        wr_base_in = PW'(rcv_ff[match_idx]) * PW'(7);
                        wr_lim_in = wr_lim_calc;
                        wr_bytes_in = cmd.bytes[63:8];
                        wr_i_in = 3'd0;
                        rcv_in[match_idx] = next_rcv[7:0];
                        time_in[match_idx] = cmd.ts;
                        state_in = BK_WRITE;
                        if (next_rcv[7:0] >= pkts_ff[match_idx]) begin
                           mode_in[match_idx] = cbtr_pkg::MODE_DONE;
                           count_in = count_ff + 16'd1;
                           rsp_in.complete_count = count_ff + 16'd1;
                           rsp_in.status = cbtr_pkg::STAT_COMPLETE;
                        end else begin
                           rsp_in.status = cbtr_pkg::STAT_DATA;
                        end
                     end
                  end
                  cbtr_pkg::OP_FETCH: begin
                     rsp_in.kind = 1'b1;
                     rsp_in.priority_res = '0;
                     rsp_in.destination = '0;
                     if (!match_found || mode_ff[match_idx] != cbtr_pkg::MODE_DONE) begin
                        rsp_in.status = cbtr_pkg::STAT_NOTHING;
                        rsp_in.pgn = '0;
                     end else begin
                        rsp_valid_in = rsp_valid_ff && rsp_stall;
                        mode_in[match_idx] = cbtr_pkg::MODE_IDLE;
                        sid_in = match_idx;
                        copy_in = CW'(clamp);
                        wmark_in = PW'(rcv_ff[match_idx]) * PW'(7);
                        fgrp_in = grp_ff[match_idx];
                        fsrc_in = cmd.src;
                        pos_in = '0;
                        byte_in = 4'd0;
                        chunk_in = '0;
                        data_in = '0;
                        state_in = BK_READ;
                     end
                  end
                  default: begin
                     rsp_in.status = cbtr_pkg::STAT_IGNORED;
                  end
               endcase
            end
         end
         BK_WRITE: begin
            ram_we = ({5'd0, wr_pos} < wr_lim_ff);
            wr_i_in = wr_i_ff + 3'd1;
            if (wr_i_ff == 3'd6) begin
               state_in = BK_IDLE;
            end
         end
         BK_READ: begin
            if (byte_ff == 4'd8 || pos_ff == copy_ff) begin
               state_in = BK_SEND;
            end else begin
               state_in = BK_CAPT;
            end
         end
         BK_CAPT: begin
            data_in[{byte_ff[2:0], 3'b000} +: 8] = cap_byte;
            byte_in = byte_ff + 4'd1;
            pos_in = pos_ff + CW'(1);
            state_in = BK_READ;
         end
         BK_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.kind = 1'b1;
               rsp_in.status = cbtr_pkg::STAT_COMPLETE;
               rsp_in.pgn = fgrp_ff;
               rsp_in.sender_addr = fsrc_ff;
               rsp_in.priority_res = '0;
               rsp_in.destination = '0;
               rsp_in.chunk_data = data_ff;
               rsp_in.chunk_len = byte_ff;
               rsp_in.message_length = 16'(copy_ff);
               rsp_in.complete_count = count_ff;
               rsp_in.last = last_chunk;
               byte_in = 4'd0;
               data_in = '0;
               chunk_in = chunk_ff + KW'(1);
               state_in = last_chunk ? BK_IDLE : BK_READ;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         timeout_ff <= cbtr_pkg::TIMEOUT_RESET;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < S; i++) begin
            mode_ff[i] <= cbtr_pkg::MODE_IDLE;
            src_ff[i] <= '0;
            len_ff[i] <= '0;
            pkts_ff[i] <= '0;
            grp_ff[i] <= '0;
            rcv_ff[i] <= '0;
            time_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         timeout_ff <= timeout_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff <= mode_in;
         src_ff <= src_in;
         len_ff <= len_in;
         pkts_ff <= pkts_in;
         grp_ff <= grp_in;
         rcv_ff <= rcv_in;
         time_ff <= time_in;
      end
      rsp_ff <= rsp_in;
      sid_ff <= sid_in;
      wr_base_ff <= wr_base_in;
      wr_lim_ff <= wr_lim_in;
      wr_bytes_ff <= wr_bytes_in;
      wr_i_ff <= wr_i_in;
      copy_ff <= copy_in;
      pos_ff <= pos_in;
      wmark_ff <= wmark_in;
      byte_ff <= byte_in;
      chunk_ff <= chunk_in;
      data_ff <= data_in;
      fgrp_ff <= fgrp_in;
      fsrc_ff <= fsrc_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule

>>> rtl/can_broadcast_transport_reassembler_core.sv
// Top level of the broadcast transport reassembler: front end, back end and checks.
//
// The request channel (req_*) takes one item per accepted valid/stall handshake: either a
// received CAN frame or a fetch of a completed message. The result channel (rsp_*) returns one
// status item per frame or fruitless fetch, else one to 32 chunk items, the last with rsp_last.
// A short two-item queue separates decoding from execution, so requests are taken while a
// result still waits in the output register.
// With the back end idle, an accepted frame is held in the queue register, then its result
// is registered in the output register. A data frame then keeps the back end in its write
// state for its seven payload byte writes into the write port of the buffer RAM.
// A fetch starts from the idle state, then takes a read and a capture state per byte on the
// buffer read port, plus a final read-state check and a send state per chunk.
// csr_we writes the packet timeout, which resets to 750 ms.
// Reset clears all sessions to idle and the completed counter to zero; no clearing pass
// runs, and bytes not yet written since an announce read back as 0xFF.
// While rsp_stall is high the held result stays, the back end waits before its next result,
// and the queue fills until req_stall rises.
module can_broadcast_transport_reassembler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [28:0] req_can_id,
   input  logic [3:0]  req_frame_length,
   input  logic [63:0] req_payload,
   input  logic [31:0] req_timestamp_ms,
   input  logic [7:0]  req_fetch_source,
   input  logic [15:0] req_fetch_max_len,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [3:0]  rsp_status,
   output logic [23:0] rsp_pgn,
   output logic [7:0]  rsp_sender_addr,
   output logic [2:0]  rsp_priority_res,
   output logic [7:0]  rsp_destination,
   output logic [63:0] rsp_chunk_data,
   output logic [3:0]  rsp_chunk_len,
   output logic [15:0] rsp_message_length,
   output logic [15:0] rsp_complete_count,
   output logic        rsp_last
);

   logic              cmd_valid, cmd_pop;
   cbtr_pkg::cmd_type cmd;
   cbtr_pkg::rsp_type rsp;

   cbtr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_can_id        (req_can_id),
      .req_frame_length  (req_frame_length),
      .req_payload       (req_payload),
      .req_timestamp_ms  (req_timestamp_ms),
      .req_fetch_source  (req_fetch_source),
      .req_fetch_max_len (req_fetch_max_len),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop)
   );

   cbtr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_kind           = rsp.kind;
   assign rsp_status         = rsp.status;
   assign rsp_pgn            = rsp.pgn;
   assign rsp_sender_addr    = rsp.sender_addr;
   assign rsp_priority_res   = rsp.priority_res;
   assign rsp_destination    = rsp.destination;
   assign rsp_chunk_data     = rsp.chunk_data;
   assign rsp_chunk_len      = rsp.chunk_len;
   assign rsp_message_length = rsp.message_length;
   assign rsp_complete_count = rsp.complete_count;
   assign rsp_last           = rsp.last;

   a_frame_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> rsp_last && rsp_chunk_len == 4'd0)
      else $error("frame result is not a single item");

   a_chunk_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_chunk_len <= 4'd8)
      else $error("chunk length above eight");

   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("queue popped while empty");

endmodule
